// ----- rtl/avt_pkg.sv -----
package avt_pkg;

  // Result and register widths fixed by the interface
  localparam int OUT_W   = 48;
  localparam int CPR_W   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [CPR_W-1:0] CPR_RESET = 16'd4096;

  // Register word index (paddr[ADDR_W-1:2])
  localparam logic [0:0] REG_CPR = 1'b0;

  // Speed saturation limits
  localparam logic [OUT_W-1:0] SPD_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SPD_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- rtl/avt_mul.sv -----
module avt_mul import avt_pkg::*; #(
  parameter int AW = 50,
  parameter int BW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [BW-1:0]        b_i,
  output logic [AW+BW-1:0]     prod_o,
  output unit_stat_t           stat_o
);

  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0] a_q, hi_q;
  logic [BW-1:0]        lo_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic signed [AW:0]   sum;

  // one multiplier bit per cycle, LSB first; product shifts right into lo_q
  assign sum = {hi_q[AW-1], hi_q} + (lo_q[0] ? {a_q[AW-1], a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CW'(BW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(BW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[AW:1];
      lo_q <= {sum[0], lo_q[BW-1:1]};
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ----- rtl/avt_div.sv -----
module avt_div import avt_pkg::*; #(
  parameter int NW = 74,
  parameter int DW = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  output logic [OUT_W-1:0] quot_o,
  output logic             ovf_o,
  output unit_stat_t       stat_o
);

  localparam int HW = NW - OUT_W;
  localparam int LW = (HW > DW) ? HW : DW;
  localparam int CW = $clog2(OUT_W + 1);

  logic [DW-1:0]    den_q, rem_q;
  logic [OUT_W-1:0] q_q;
  logic             ovf_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  logic [LW-1:0]    hi_ext, den_ext;
  logic [DW:0]      rem2, diff;
  logic             ge;

  // quotient >= 2^OUT_W iff the numerator's upper part is not below the divisor
  assign hi_ext  = LW'(num_i[NW-1:OUT_W]);
  assign den_ext = LW'(den_i);

  // restoring step: one quotient bit per cycle
  assign rem2 = {rem_q, q_q[OUT_W-1]};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = !diff[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CW'(OUT_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(OUT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= hi_ext[DW-1:0];
      q_q   <= num_i[OUT_W-1:0];
      ovf_q <= (hi_ext >= den_ext);
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : rem2[DW-1:0];
      q_q   <= {q_q[OUT_W-2:0], ge};
    end
  end

  assign quot_o = q_q;
  assign ovf_o  = ovf_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ----- rtl/multiturn_angle_velocity_tracker_top.sv -----
// Multi-turn angle and velocity tracker. Each input beat carries a raw absolute
// encoder count and a sample of a free-running down-counting tick timer; each
// yields one result beat with the multi-turn angle (rotations * counts_per_rev
// + raw, in counts), the speed in counts per second (truncated toward zero,
// saturated to signed 48 bits) and a flag set when the elapsed time was zero or
// over half a second and 1 ms was used instead. A raw jump of more than 0.8 of
// a turn counts as a wrap. The first beat after reset primes the previous raw
// count, so it sees no wrap. One beat is in work at a time: two passes through
// the shared bit-serial multiplier (angle, then delta times ticks per second,
// each with an MW-bit multiplier, where MW is the larger of 16 and the bit
// width of the ticks-per-second constant), then the 48-step restoring divider.
// The result sits in an output register, so the next beat is taken while it
// waits. counts_per_rev sits at byte address 0 of the APB port and is to be
// written only while idle by the user; the block itself does not enforce this.
module multiturn_angle_velocity_tracker_top import avt_pkg::*; #(
  parameter int RAW_BITS      = 15,
  parameter int TIMER_BITS    = 24,
  parameter int TICKS_PER_US  = 9,
  parameter int ROTATION_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // APB config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RAW_BITS-1:0]     raw_count_i,
  input  logic [TIMER_BITS-1:0]   timer_now_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] full_angle_o,
  output logic signed [OUT_W-1:0] speed_o,
  output logic                    dt_fallback_o
);

  // Arithmetic widths
  localparam int     AW         = OUT_W + 2;      // multiplicand: angle delta magnitude
  localparam longint TPS        = longint'(TICKS_PER_US) * 1000000;
  localparam int     TPS_BITS   = $clog2(TPS + 1);
  localparam int     MW         = (TPS_BITS > CPR_W) ? TPS_BITS : CPR_W;
  localparam int     NW         = AW + MW;
  localparam longint FB_TICKS   = longint'(TICKS_PER_US) * 1000;
  localparam longint HALF_TICKS = longint'(TICKS_PER_US) * 500000;
  localparam int     FB_BITS    = $clog2(FB_TICKS + 1);
  localparam int     TK_W       = (TIMER_BITS > FB_BITS) ? TIMER_BITS : FB_BITS;
  localparam int     CW         = (RAW_BITS + 3 > CPR_W + 2) ? RAW_BITS + 3 : CPR_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_ANG,
    S_DELTA,
    S_MUL_SPD,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  // config
  logic [CPR_W-1:0] cpr_q;
  logic             cfg_wr;

  // tracking state
  logic [RAW_BITS-1:0]             last_raw_q;
  logic signed [ROTATION_BITS-1:0] rot_q;
  logic [OUT_W-1:0]                last_full_q;
  logic [TIMER_BITS-1:0]           last_timer_q;
  logic                            primed_q;

  // per-item work registers
  logic [RAW_BITS-1:0]    raw_q;
  logic [TK_W-1:0]        ticks_q;
  logic                   fb_q;
  logic [OUT_W-1:0]       full_q;
  logic                   neg_q;
  logic [OUT_W-1:0]       speed_q;

  // output register
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_full_q, out_speed_q;
  logic                   out_fb_q;

  // arithmetic units
  logic signed [AW-1:0]   mul_a_q;
  logic [MW-1:0]          mul_b_q;
  logic                   mul_start_q, div_start_q;
  logic [NW-1:0]          mul_prod;
  unit_stat_t             mul_stat, div_stat;
  logic [OUT_W-1:0]       div_quot;
  logic                   div_ovf;

  // front-end combinational
  logic [RAW_BITS-1:0]             raw_prev;
  logic [RAW_BITS:0]               diff, diff_n;
  logic                            diff_neg;
  logic [RAW_BITS-1:0]             adiff;
  logic [CW-1:0]                   ad5, cpr4;
  logic                            wrap;
  logic signed [ROTATION_BITS-1:0] rot_nx;
  logic [TIMER_BITS-1:0]           tk_raw;
  logic                            fallback;
  logic                            in_fire;

  // delta / speed combinational
  logic [OUT_W:0]   d_fwd, d_rev, mag;
  logic             d_neg;
  logic [OUT_W-1:0] spd_pos, spd_neg;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[ADDR_W-1:2] == REG_CPR) ? DATA_W'(cpr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CPR_RESET;
    end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_CPR) begin
      cpr_q <= pwdata[CPR_W-1:0];
    end
  end

  // ---------------- wrap detect and elapsed ticks ----------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    // unprimed: compare against itself so no wrap is seen
    raw_prev = primed_q ? last_raw_q : raw_count_i;
    diff     = {1'b0, raw_count_i} - {1'b0, raw_prev};
    diff_n   = -diff;
    diff_neg = diff[RAW_BITS];
    adiff    = diff_neg ? diff_n[RAW_BITS-1:0] : diff[RAW_BITS-1:0];
    // wrap when 5*|d| > 4*cpr
    ad5      = CW'({adiff, 2'b00}) + CW'(adiff);
    cpr4     = CW'({cpr_q, 2'b00});
    wrap     = ad5 > cpr4;
    // forward jump across the wrap means we went backward a turn
    if (!wrap) begin
      rot_nx = rot_q;
    end else if (diff_neg) begin
      rot_nx = rot_q + ROTATION_BITS'(1);
    end else begin
      rot_nx = rot_q - ROTATION_BITS'(1);
    end

    // down-counter: elapsed = last - now, else wrapped through all-ones
    if (timer_now_i < last_timer_q) begin
      tk_raw = last_timer_q - timer_now_i;
    end else begin
      tk_raw = ~timer_now_i + last_timer_q;
    end
    fallback = (tk_raw == '0) || (64'(tk_raw) > 64'(HALF_TICKS));
  end

  // ---------------- angle delta ----------------
  // both orders in parallel so the magnitude needs no negate after subtract
  always_comb begin
    d_fwd = {full_q[OUT_W-1], full_q} - {last_full_q[OUT_W-1], last_full_q};
    d_rev = {last_full_q[OUT_W-1], last_full_q} - {full_q[OUT_W-1], full_q};
    d_neg = d_fwd[OUT_W];
    mag   = d_neg ? d_rev : d_fwd;
  end

  // ---------------- speed saturation ----------------
  always_comb begin
    spd_pos = (div_ovf || div_quot[OUT_W-1]) ? SPD_MAX : div_quot;
    spd_neg = (div_ovf || div_quot > SPD_MIN) ? SPD_MIN : (~div_quot + OUT_W'(1));
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      last_raw_q   <= '0;
      rot_q        <= '0;
      last_full_q  <= '0;
      last_timer_q <= '0;
      primed_q     <= 1'b0;
      raw_q        <= '0;
      ticks_q      <= '0;
      fb_q         <= 1'b0;
      full_q       <= '0;
      neg_q        <= 1'b0;
      speed_q      <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      mul_start_q  <= 1'b0;
      div_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_full_q   <= '0;
      out_speed_q  <= '0;
      out_fb_q     <= 1'b0;
    end else begin
      // unit starts are single-cycle pulses
      mul_start_q <= in_fire || (state_q == S_DELTA);
      div_start_q <= (state_q == S_MUL_SPD) && mul_stat.done;
      // S_OUT reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            primed_q     <= 1'b1;
            last_raw_q   <= raw_count_i;
            rot_q        <= rot_nx;
            last_timer_q <= timer_now_i;
            raw_q        <= raw_count_i;
            fb_q         <= fallback;
            ticks_q      <= fallback ? TK_W'(FB_TICKS) : TK_W'(tk_raw);
            // rotations * cpr
            mul_a_q      <= {{(AW-ROTATION_BITS){rot_nx[ROTATION_BITS-1]}}, rot_nx};
            mul_b_q      <= MW'(cpr_q);
            state_q      <= S_MUL_ANG;
          end
        end
        S_MUL_ANG: begin
          if (mul_stat.done) begin
            full_q  <= mul_prod[OUT_W-1:0] + OUT_W'(raw_q);
            state_q <= S_DELTA;
          end
        end
        S_DELTA: begin
          last_full_q <= full_q;
          neg_q       <= d_neg;
          // |delta| * ticks per second
          mul_a_q     <= $signed({1'b0, mag});
          mul_b_q     <= MW'(TPS);
          state_q     <= S_MUL_SPD;
        end
        S_MUL_SPD: begin
          if (mul_stat.done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            speed_q <= neg_q ? spd_neg : spd_pos;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_full_q  <= full_q;
            out_speed_q <= speed_q;
            out_fb_q    <= fb_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  avt_mul #(
    .AW(AW),
    .BW(MW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .prod_o (mul_prod),
    .stat_o (mul_stat)
  );

  avt_div #(
    .NW(NW),
    .DW(TK_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (mul_prod),
    .den_i  (ticks_q),
    .quot_o (div_quot),
    .ovf_o  (div_ovf),
    .stat_o (div_stat)
  );

  assign out_valid_o   = out_valid_q;
  assign full_angle_o  = $signed(out_full_q);
  assign speed_o       = $signed(out_speed_q);
  assign dt_fallback_o = out_fb_q;

  // ---------------- assertions ----------------
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!mul_stat.busy && !div_stat.busy))
    else $error("input taken while arithmetic still running");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> (ticks_q != '0))
    else $error("divider started with zero ticks");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == S_MUL_ANG || state_q == S_MUL_SPD))
    else $error("multiplier finished outside a multiply state");

endmodule
